### rtl/tsc_pkg.sv
package tsc_pkg;

  localparam int unsigned TEMP_W = 7;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned IDX_W  = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_SETTING    = 2'd1,
    MODE_REGULATING = 2'd2
  } mode_t;

  localparam logic [1:0] REQ_UP   = 2'd0;
  localparam logic [1:0] REQ_DOWN = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [IDX_W-1:0] CFG_INITIAL = 3'd0;
  localparam logic [IDX_W-1:0] CFG_MIN     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MAX     = 3'd2;
  localparam logic [IDX_W-1:0] CFG_STEP    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_BAND    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_TIMEOUT = 3'd5;

  localparam logic [TEMP_W-1:0] RST_INITIAL = 7'd60;
  localparam logic [TEMP_W-1:0] RST_MIN     = 7'd35;
  localparam logic [TEMP_W-1:0] RST_MAX     = 7'd75;
  localparam logic [NIB_W-1:0]  RST_STEP    = 4'd5;
  localparam logic [NIB_W-1:0]  RST_BAND    = 4'd5;
  localparam logic [NIB_W-1:0]  RST_TIMEOUT = 4'd5;

  localparam logic [NIB_W-1:0]  IDLE_MAX    = 4'd15;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TEMP_W-1:0] temp_now;
    logic              power_on;
  } req_t;

  typedef struct packed {
    logic [TEMP_W-1:0] display_value;
    logic              display_enable;
    logic              heater_drive;
    logic              cooler_drive;
    logic              indicator_led;
    logic [1:0]        current_mode;
  } res_t;

  typedef struct packed {
    logic [TEMP_W-1:0] initial_setpoint;
    logic [TEMP_W-1:0] min_setpoint;
    logic [TEMP_W-1:0] max_setpoint;
    logic [NIB_W-1:0]  step_size;
    logic [NIB_W-1:0]  band_width;
    logic [NIB_W-1:0]  timeout_ticks;
  } cfg_t;

endpackage

### rtl/thermostat_setpoint_controller.sv
// Thermostat set-point controller.
//
// Request channel: req_valid / req_stall / req_data carry up presses, down
// presses and one-second ticks, each with the sensor temperature and the
// power switch level. Response channel: res_valid / res_stall / res_data
// give one status word per request (display, heater, cooler, LED, mode).
// Configuration: cfg_write / cfg_index / cfg_data write the six settings
// (initial, min and max set point, step, band, timeout); write only while idle.
//
// Path: a taken request enters the input register, then the state update
// writes its status into the result register.
// Throughput: one request per cycle until a stalled response fills the input
// register; the state update is combinational compare and add logic.
//
// Reset: normal mode, set point 60, flags off, settings at their defaults,
// both channels empty.
// A stalled response holds; the request taken behind it waits in the input
// register, and req_stall rises only while both registers are full and
// res_stall is high.
module thermostat_setpoint_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  tsc_pkg::req_t              req_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output tsc_pkg::res_t              res_data,
  input  logic                       cfg_write,
  input  logic [tsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tsc_pkg::TEMP_W-1:0] cfg_data
);
  import tsc_pkg::*;

  cfg_t cfg;
  req_t req_q;
  logic req_q_valid;
  logic advance;
  res_t result;

  assign advance   = req_q_valid && (!res_valid || !res_stall);
  assign req_stall = req_q_valid && res_valid && res_stall;

  tsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .req    (req_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= result;
    end
  end

endmodule

### rtl/tsc_cfg.sv
module tsc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tsc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tsc_pkg::TEMP_W-1:0]    cfg_data,
  output tsc_pkg::cfg_t                 cfg
);
  import tsc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_setpoint <= RST_INITIAL;
      cfg.min_setpoint     <= RST_MIN;
      cfg.max_setpoint     <= RST_MAX;
      cfg.step_size        <= RST_STEP;
      cfg.band_width       <= RST_BAND;
      cfg.timeout_ticks    <= RST_TIMEOUT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INITIAL: cfg.initial_setpoint <= cfg_data;
        CFG_MIN:     cfg.min_setpoint     <= cfg_data;
        CFG_MAX:     cfg.max_setpoint     <= cfg_data;
        CFG_STEP:    cfg.step_size        <= cfg_data[NIB_W-1:0];
        CFG_BAND:    cfg.band_width       <= cfg_data[NIB_W-1:0];
        CFG_TIMEOUT: cfg.timeout_ticks    <= cfg_data[NIB_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/tsc_core.sv
module tsc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  tsc_pkg::req_t req,
  input  tsc_pkg::cfg_t cfg,
  output tsc_pkg::res_t result
);
  import tsc_pkg::*;

  mode_t             mode_state, mode_state_next;
  logic [TEMP_W-1:0] set_point, set_point_next;
  logic [TEMP_W-1:0] target_temp, target_temp_next;
  logic [NIB_W-1:0]  idle_ticks, idle_ticks_next;
  logic              heater_flag, heater_flag_next;
  logic              cooler_flag, cooler_flag_next;
  logic              led_flag, led_flag_next;
  logic [TEMP_W-1:0] shown_value, shown_value_next;

  logic [TEMP_W:0]   up_sum;
  logic [TEMP_W:0]   down_floor;
  logic [TEMP_W-1:0] up_value;
  logic [TEMP_W-1:0] down_value;
  logic [NIB_W-1:0]  idle_inc;
  logic signed [TEMP_W+1:0] diff;
  logic signed [TEMP_W+1:0] band_pos;
  logic signed [TEMP_W+1:0] band_neg;
  logic              is_press;

  assign up_sum     = {1'b0, set_point} + {{(TEMP_W+1-NIB_W){1'b0}}, cfg.step_size};
  assign up_value   = (up_sum > {1'b0, cfg.max_setpoint}) ? cfg.max_setpoint
                                                          : up_sum[TEMP_W-1:0];
  assign down_floor = {1'b0, cfg.min_setpoint}
                    + {{(TEMP_W+1-NIB_W){1'b0}}, cfg.step_size};
  assign down_value = ({1'b0, set_point} < down_floor) ? cfg.min_setpoint
                    : set_point - {{(TEMP_W-NIB_W){1'b0}}, cfg.step_size};
  assign idle_inc   = (idle_ticks < IDLE_MAX) ? idle_ticks + 4'd1 : idle_ticks;
  assign diff       = $signed({2'b00, target_temp}) - $signed({2'b00, req.temp_now});
  assign band_pos   = $signed({{(TEMP_W+2-NIB_W){1'b0}}, cfg.band_width});
  assign band_neg   = -band_pos;
  assign is_press   = (req.req_type == REQ_UP) || (req.req_type == REQ_DOWN);

  always_comb begin
    mode_state_next  = mode_state;
    set_point_next   = set_point;
    target_temp_next = target_temp;
    idle_ticks_next  = idle_ticks;
    heater_flag_next = heater_flag;
    cooler_flag_next = cooler_flag;
    led_flag_next    = led_flag;
    shown_value_next = shown_value;

    if (is_press) begin
      case (mode_state)
        MODE_NORMAL: begin
          mode_state_next  = MODE_SETTING;
          set_point_next   = cfg.initial_setpoint;
          idle_ticks_next  = '0;
          shown_value_next = cfg.initial_setpoint;
        end
        MODE_SETTING: begin
          idle_ticks_next  = '0;
          set_point_next   = (req.req_type == REQ_UP) ? up_value : down_value;
          shown_value_next = set_point_next;
        end
        default: ;
      endcase
    end else if (req.req_type == REQ_TICK && req.power_on) begin
      case (mode_state)
        MODE_SETTING: begin
          shown_value_next = set_point;
          idle_ticks_next  = idle_inc;
          if (idle_inc >= cfg.timeout_ticks) begin
            target_temp_next = set_point;
            idle_ticks_next  = '0;
            mode_state_next  = MODE_REGULATING;
            set_point_next   = cfg.initial_setpoint;
          end
        end
        MODE_REGULATING: begin
          shown_value_next = req.temp_now;
          if (diff > band_pos) begin
            heater_flag_next = 1'b1;
            cooler_flag_next = 1'b0;
            led_flag_next    = ~led_flag;
          end else if (diff <= band_neg) begin
            heater_flag_next = 1'b0;
            cooler_flag_next = 1'b1;
            led_flag_next    = 1'b1;
          end else begin
            heater_flag_next = 1'b0;
            cooler_flag_next = 1'b0;
            led_flag_next    = 1'b0;
            mode_state_next  = MODE_NORMAL;
          end
        end
        default: shown_value_next = req.temp_now;
      endcase
    end

    if (!req.power_on) begin
      heater_flag_next = 1'b0;
      cooler_flag_next = 1'b0;
      led_flag_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state  <= MODE_NORMAL;
      set_point   <= RST_INITIAL;
      target_temp <= '0;
      idle_ticks  <= '0;
      heater_flag <= 1'b0;
      cooler_flag <= 1'b0;
      led_flag    <= 1'b0;
      shown_value <= '0;
    end else if (step) begin
      mode_state  <= mode_state_next;
      set_point   <= set_point_next;
      target_temp <= target_temp_next;
      idle_ticks  <= idle_ticks_next;
      heater_flag <= heater_flag_next;
      cooler_flag <= cooler_flag_next;
      led_flag    <= led_flag_next;
      shown_value <= shown_value_next;
    end
  end

  always_comb begin
    result.display_value  = req.power_on ? shown_value_next : '0;
    result.display_enable = req.power_on;
    result.heater_drive   = heater_flag_next;
    result.cooler_drive   = cooler_flag_next;
    result.indicator_led  = led_flag_next;
    result.current_mode   = mode_state_next;
  end

endmodule

### rtl/tsc_checker.sv
module tsc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_stall,
  input logic                       res_valid,
  input logic                       res_stall,
  input tsc_pkg::res_t              res_data
);
  import tsc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled response changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> ##2 res_valid)
    else $error("response missing two cycles after request");

  a_power_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.display_enable |->
      !res_data.heater_drive && !res_data.cooler_drive &&
      !res_data.indicator_led && res_data.display_value == '0)
    else $error("outputs active with power off");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.heater_drive && res_data.cooler_drive) &&
      (!(res_data.heater_drive || res_data.cooler_drive) ||
       res_data.current_mode == MODE_REGULATING))
    else $error("heater and cooler conflict or drive outside regulation");

endmodule

bind thermostat_setpoint_controller tsc_checker u_tsc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

### dv/thermostat_setpoint_controller_test.sv
`timescale 1ns / 1ps

module thermostat_setpoint_controller_test;
  import tsc_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [TEMP_W-1:0] cfg_data = '0;

  thermostat_setpoint_controller u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  cfg_t cfg_model = '{RST_INITIAL, RST_MIN, RST_MAX, RST_STEP, RST_BAND, RST_TIMEOUT};
  mode_t therm_mode = MODE_NORMAL;
  logic [TEMP_W-1:0] therm_setp = RST_INITIAL;
  logic [TEMP_W-1:0] therm_target = '0;
  logic [NIB_W-1:0] therm_idle = '0;
  logic therm_heat = 1'b0;
  logic therm_cool = 1'b0;
  logic therm_led = 1'b0;
  logic [TEMP_W-1:0] therm_shown = '0;

  req_t request_queue[$];
  res_t expected_status[$];
  int requests_queued = 0;
  int requests_taken = 0;
  int mismatches = 0;
  logic req_fire = 1'b0;

  int gap_left = 0;
  int burst_left = 0;
  bit drain_wait = 1'b0;
  int stall_mode = 0;
  int stall_count = 0;

  function automatic res_t thermostat_step(req_t r);
    res_t s;
    int v;
    int diff;
    int band;
    if (r.req_type == REQ_UP || r.req_type == REQ_DOWN) begin
      if (therm_mode == MODE_NORMAL) begin
        therm_mode = MODE_SETTING;
        therm_setp = cfg_model.initial_setpoint;
        therm_idle = '0;
        therm_shown = therm_setp;
      end else if (therm_mode == MODE_SETTING) begin
        therm_idle = '0;
        if (r.req_type == REQ_UP) begin
          v = int'(therm_setp) + int'(cfg_model.step_size);
          if (v > int'(cfg_model.max_setpoint)) v = int'(cfg_model.max_setpoint);
        end else begin
          v = int'(therm_setp) - int'(cfg_model.step_size);
          if (v < int'(cfg_model.min_setpoint)) v = int'(cfg_model.min_setpoint);
        end
        therm_setp = v[TEMP_W-1:0];
        therm_shown = therm_setp;
      end
    end else if (r.req_type == REQ_TICK && r.power_on) begin
      if (therm_mode == MODE_SETTING) begin
        therm_shown = therm_setp;
        if (therm_idle < IDLE_MAX) therm_idle = therm_idle + 4'd1;
        if (therm_idle >= cfg_model.timeout_ticks) begin
          therm_target = therm_setp;
          therm_idle = '0;
          therm_mode = MODE_REGULATING;
          therm_setp = cfg_model.initial_setpoint;
        end
      end else if (therm_mode == MODE_REGULATING) begin
        diff = int'(therm_target) - int'(r.temp_now);
        band = int'(cfg_model.band_width);
        if (diff > band) begin
          therm_heat = 1'b1;
          therm_cool = 1'b0;
          therm_led = ~therm_led;
        end else if (diff <= -band) begin
          therm_heat = 1'b0;
          therm_cool = 1'b1;
          therm_led = 1'b1;
        end else begin
          therm_heat = 1'b0;
          therm_cool = 1'b0;
          therm_led = 1'b0;
          therm_mode = MODE_NORMAL;
        end
        therm_shown = r.temp_now;
      end else begin
        therm_shown = r.temp_now;
      end
    end
    if (!r.power_on) begin
      therm_heat = 1'b0;
      therm_cool = 1'b0;
      therm_led = 1'b0;
    end
    s.display_value = r.power_on ? therm_shown : '0;
    s.display_enable = r.power_on;
    s.heater_drive = therm_heat;
    s.cooler_drive = therm_cool;
    s.indicator_led = therm_led;
    s.current_mode = therm_mode;
    return s;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: check results, then record the prediction for the request taken
  always @(posedge clk) begin : monitor
    res_t want;
    req_fire <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected status, expected none, actual %h", $time, res_data);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("display_value", want.display_value, res_data.display_value);
          check_field("display_enable", want.display_enable, res_data.display_enable);
          check_field("heater_drive", want.heater_drive, res_data.heater_drive);
          check_field("cooler_drive", want.cooler_drive, res_data.cooler_drive);
          check_field("indicator_led", want.indicator_led, res_data.indicator_led);
          check_field("current_mode", want.current_mode, res_data.current_mode);
        end
      end
      if (req_valid && !req_stall) begin
        expected_status.push_back(thermostat_step(req_data));
        requests_taken++;
      end
    end
  end

  always @(negedge clk) begin : driver
    logic next_valid;
    if (!rst && !(req_valid && !req_fire)) begin
      next_valid = 1'b0;
      if (drain_wait) begin
        if (expected_status.size() == 0) drain_wait = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (request_queue.size() > 0) begin
        req_data <= request_queue.pop_front();
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          drain_wait = ($urandom_range(0, 30) == 0);
        end
      end
      req_valid <= next_valid;
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (stall_count == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_count = $urandom_range(20, 80);
      end else begin
        stall_count--;
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= stall_count[2];
      endcase
    end
  end

  task automatic add_request(logic [1:0] kind, int temp, bit power);
    req_t r;
    r.req_type = kind;
    r.temp_now = temp[TEMP_W-1:0];
    r.power_on = power;
    request_queue.push_back(r);
    requests_queued++;
  endtask

  function automatic int pick_temp();
    int lo;
    int hi;
    lo = int'(cfg_model.initial_setpoint);
    hi = lo;
    if (int'(cfg_model.min_setpoint) < lo) lo = int'(cfg_model.min_setpoint);
    if (int'(cfg_model.max_setpoint) < lo) lo = int'(cfg_model.max_setpoint);
    if (int'(cfg_model.min_setpoint) > hi) hi = int'(cfg_model.min_setpoint);
    if (int'(cfg_model.max_setpoint) > hi) hi = int'(cfg_model.max_setpoint);
    lo = lo - int'(cfg_model.band_width) - 2;
    hi = hi + int'(cfg_model.band_width) + 2;
    if (lo < 0) lo = 0;
    if (hi > 99) hi = 99;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 99);
    return $urandom_range(hi, lo);
  endfunction

  function automatic bit pick_power();
    return ($urandom_range(0, 15) != 0);
  endfunction

  // one set-point session: presses, idle ticks to the timeout, then regulation
  task automatic queue_session();
    int presses;
    int gaps;
    int ticks;
    presses = $urandom_range(1, 8);
    for (int i = 0; i < presses; i++) begin
      add_request($urandom_range(0, 1) ? REQ_UP : REQ_DOWN, pick_temp(), pick_power());
      gaps = ($urandom_range(0, 2) == 0) ? $urandom_range(0, cfg_model.timeout_ticks - 1) : 0;
      for (int g = 0; g < gaps; g++) add_request(REQ_TICK, pick_temp(), pick_power());
      if ($urandom_range(0, 7) == 0) begin
        add_request(REQ_SPARE, $urandom_range(0, 99), 1'($urandom_range(0, 1)));
      end
    end
    ticks = int'(cfg_model.timeout_ticks) + $urandom_range(0, 1);
    for (int i = 0; i < ticks; i++) add_request(REQ_TICK, pick_temp(), pick_power());
    ticks = $urandom_range(1, 12);
    for (int i = 0; i < ticks; i++) add_request(REQ_TICK, pick_temp(), pick_power());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (requests_taken != requests_queued || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [TEMP_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic apply_settings(cfg_t c);
    write_reg(CFG_INITIAL, c.initial_setpoint);
    write_reg(CFG_MIN, c.min_setpoint);
    write_reg(CFG_MAX, c.max_setpoint);
    write_reg(CFG_STEP, TEMP_W'(c.step_size));
    write_reg(CFG_BAND, TEMP_W'(c.band_width));
    write_reg(CFG_TIMEOUT, TEMP_W'(c.timeout_ticks));
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_model = c;
  endtask

  task automatic queue_random(int count);
    int start;
    start = requests_queued;
    while (requests_queued - start < count) queue_session();
  endtask

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_request(REQ_TICK, 0, 1'b1);
    add_request(REQ_TICK, 99, 1'b1);
    add_request(REQ_SPARE, 42, 1'b1);
    add_request(REQ_DOWN, 7, 1'b1);
    for (int i = 0; i < 6; i++) add_request(REQ_DOWN, 20 + i, 1'b1);
    add_request(REQ_UP, 30, 1'b0);
    add_request(REQ_TICK, 30, 1'b0);
    for (int i = 0; i < 5; i++) add_request(REQ_TICK, 50, 1'b1);
    add_request(REQ_TICK, 0, 1'b1);
    add_request(REQ_TICK, 1, 1'b1);
    add_request(REQ_UP, 0, 1'b1);
    add_request(REQ_TICK, 99, 1'b1);
    add_request(REQ_TICK, 45, 1'b1);
    add_request(REQ_TICK, 35, 1'b1);
    wait_drained();

    apply_settings('{7'd0, 7'd0, 7'd30, 4'd15, 4'd0, 4'd1});
    for (int i = 0; i < 4; i++) add_request(REQ_UP, 10, 1'b1);
    add_request(REQ_TICK, 10, 1'b1);
    add_request(REQ_TICK, 30, 1'b1);
    add_request(REQ_TICK, 29, 1'b1);
    wait_drained();

    apply_settings('{7'd99, 7'd99, 7'd0, 4'd1, 4'd15, 4'd15});
    queue_random(100);
    wait_drained();

    apply_settings('{7'd99, 7'd0, 7'd99, 4'd15, 4'd15, 4'd1});
    queue_random(100);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      c.initial_setpoint = TEMP_W'($urandom_range(0, 99));
      c.min_setpoint = TEMP_W'($urandom_range(0, 99));
      c.max_setpoint = TEMP_W'($urandom_range(0, 99));
      c.step_size = NIB_W'($urandom_range(1, 15));
      c.band_width = NIB_W'($urandom_range(0, 15));
      c.timeout_ticks = NIB_W'($urandom_range(1, 15));
      apply_settings(c);
      queue_random(100);
      wait_drained();
    end

    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
